/* rtl/core/pps_pkg.sv */
// Package for the projection profile segmenter.
// Holds field widths, parameter defaults, register indexes and the result entry type.
// No dependencies.
`timescale 1ns / 1ps

package pps_pkg;

  // Default profile length; the position counter saturates at one below it.
  localparam int unsigned MAX_LENGTH_DEFAULT = 4096;

  // Fixed widths of the transaction fields.
  localparam int unsigned VALUE_W  = 13;
  localparam int unsigned START_W  = 12;
  localparam int unsigned LENGTH_W = 13;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned CFG_IDX_W = 2;

  // Depth of the result queue; it must hold the two results of one item.
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INK_THRESHOLD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_OBJECT_LENGTH = 2'd2;

  typedef struct packed {
    logic [START_W-1:0]  seg_start;
    logic [LENGTH_W-1:0] seg_length;
    logic                seg_valid;
    logic                frame_done;
    logic                run_last;
  } result_t;

endpackage

/* rtl/core/projection_profile_segmenter.sv */
// Projection profile segmenter: top level, segmentation logic and result queue.
// Depends on pps_pkg for widths, register indexes and the result entry type.
`timescale 1ns / 1ps

// Takes one projection value per row or column and cuts the profile into objects.
// A value above ink_threshold is ink, anything else is gap; a gap run of at least
// min_gap_length (0 behaves as 1) closes the open object, a shorter gap followed by
// ink is absorbed. A closed object spanning at least min_object_length positions is
// reported with its start and length. The item flagged final_position flushes any
// open object and then yields a bare end marker with frame_done set; run_last marks
// the last result of each item. Rate: one input transaction per clock cycle while
// in_stall_o is low; each item is classified and the state updated in the cycle it is
// accepted, and its zero, one or two results land in a four-entry result queue that
// drains one result a cycle while out_stall_i is low. Input is held off only while
// that queue could not take two more results. Positions past MAX_LENGTH-1 saturate.
// Configuration is written through cfg_we_i / cfg_idx_i /
// cfg_data_i while the block is idle; an index beyond the register list is ignored.
module projection_profile_segmenter
  import pps_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [VALUE_W-1:0]   proj_value_i,
  input  logic                 final_position_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [START_W-1:0]   seg_start_o,
  output logic [LENGTH_W-1:0]  seg_length_o,
  output logic                 seg_valid_o,
  output logic                 frame_done_o,
  output logic                 run_last_o
);

  // Position width follows the profile length; lengths need one bit more.
  localparam int unsigned POS_W = $clog2(MAX_LENGTH);
  localparam int unsigned LEN_W = POS_W + 1;
  // Common width for compares against the 13-bit registers and for field slicing.
  localparam int unsigned CMP_W = (LEN_W > LENGTH_W) ? LEN_W : LENGTH_W;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LENGTH - 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_INK,
    PH_GAP
  } phase_e;

  // Configuration registers.
  logic [CFG_W-1:0] ink_thr_q;
  logic [CFG_W-1:0] min_gap_q;
  logic [CFG_W-1:0] min_obj_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ink_thr_q <= '0;
      min_gap_q <= CFG_W'(1);
      min_obj_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INK_THRESHOLD:     ink_thr_q <= cfg_data_i;
        REG_MIN_GAP_LENGTH:    min_gap_q <= cfg_data_i;
        REG_MIN_OBJECT_LENGTH: min_obj_q <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Segmentation state.
  phase_e           phase_q, phase_d;
  logic [POS_W-1:0] obj_beg_q, obj_beg_d;
  logic [POS_W-1:0] gap_beg_q, gap_beg_d;
  logic [POS_W-1:0] pos_q, pos_d;

  logic             in_accept;
  logic             ink;
  logic [CFG_W-1:0] need;
  logic [CMP_W-1:0] gap_run;
  logic             close_hit;
  logic [LEN_W-1:0] close_end;
  logic [LEN_W-1:0] obj_len;
  logic             obj_emit;
  logic [CMP_W-1:0] start_ext;
  logic [CMP_W-1:0] len_ext;
  result_t          obj_res;
  result_t          mark_res;

  assign in_accept = in_valid_i && !in_stall_o;

  // Classify the item and advance the phase; at most one object closes per item.
  always_comb begin
    ink       = proj_value_i > ink_thr_q;
    need      = (min_gap_q == '0) ? CFG_W'(1) : min_gap_q;
    phase_d   = phase_q;
    obj_beg_d = obj_beg_q;
    gap_beg_d = gap_beg_q;
    pos_d     = pos_q;
    gap_run   = '0;
    close_hit = 1'b0;
    close_end = '0;

    if (ink) begin
      if (phase_q == PH_IDLE) begin
        obj_beg_d = pos_q;
      end
      phase_d = PH_INK;
    end else begin
      case (phase_q)
        PH_INK, PH_GAP: begin
          if (phase_q == PH_INK) begin
            gap_beg_d = pos_q;
            phase_d   = PH_GAP;
          end
          gap_run = CMP_W'(pos_q) - CMP_W'(gap_beg_d) + CMP_W'(1);
          // gap long enough: close the object at its last ink position
          if (gap_run >= CMP_W'(need)) begin
            close_hit = 1'b1;
            close_end = LEN_W'(gap_beg_d);
            phase_d   = PH_IDLE;
          end
        end
        default: ;
      endcase
    end

    if (final_position_i) begin
      // flush whatever is still open, then restart the profile
      if (phase_d == PH_INK) begin
        close_hit = 1'b1;
        close_end = LEN_W'(pos_q) + LEN_W'(1);
      end else if (phase_d == PH_GAP) begin
        close_hit = 1'b1;
        close_end = LEN_W'(gap_beg_d);
      end
      phase_d = PH_IDLE;
      pos_d   = '0;
    end else if (pos_q < POS_MAX) begin
      pos_d = pos_q + POS_W'(1);
    end

    obj_len  = close_end - LEN_W'(obj_beg_d);
    obj_emit = close_hit && (CMP_W'(obj_len) >= CMP_W'(min_obj_q));

    start_ext = CMP_W'(obj_beg_d);
    len_ext   = CMP_W'(obj_len);

    obj_res.seg_start  = start_ext[START_W-1:0];
    obj_res.seg_length = len_ext[LENGTH_W-1:0];
    obj_res.seg_valid  = 1'b1;
    obj_res.frame_done = 1'b0;
    obj_res.run_last   = !final_position_i;

    mark_res.seg_start  = '0;
    mark_res.seg_length = '0;
    mark_res.seg_valid  = 1'b0;
    mark_res.frame_done = 1'b1;
    mark_res.run_last   = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      obj_beg_q <= '0;
      gap_beg_q <= '0;
      pos_q     <= '0;
    end else if (in_accept) begin
      phase_q   <= phase_d;
      obj_beg_q <= obj_beg_d;
      gap_beg_q <= gap_beg_d;
      pos_q     <= pos_d;
    end
  end

  // Result queue: up to two pushes and one pop per cycle.
  result_t              res_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [RES_CNT_W-1:0] cnt_q;
  logic [1:0]           push_n;
  logic                 pop;
  logic [RES_PTR_W-1:0] wr_ptr_nx;

  assign push_n    = in_accept ? (2'(obj_emit) + 2'(final_position_i)) : 2'd0;
  assign pop       = out_valid_o && !out_stall_i;
  assign wr_ptr_nx = wr_ptr_q + RES_PTR_W'(1);

  // Hold off input until two free slots are guaranteed.
  assign in_stall_o = cnt_q > RES_CNT_W'(RES_DEPTH - 2);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      if (obj_emit) begin
        res_q[wr_ptr_q] <= obj_res;
        if (final_position_i) begin
          res_q[wr_ptr_nx] <= mark_res;
        end
      end else if (final_position_i) begin
        res_q[wr_ptr_q] <= mark_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + RES_PTR_W'(push_n);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
      end
      cnt_q <= cnt_q + RES_CNT_W'(push_n) - RES_CNT_W'(pop);
    end
  end

  assign out_valid_o  = cnt_q != '0;
  assign seg_start_o  = res_q[rd_ptr_q].seg_start;
  assign seg_length_o = res_q[rd_ptr_q].seg_length;
  assign seg_valid_o  = res_q[rd_ptr_q].seg_valid;
  assign frame_done_o = res_q[rd_ptr_q].frame_done;
  assign run_last_o   = res_q[rd_ptr_q].run_last;

endmodule

/* sim/projection_profile_segmenter_tb.sv */
// Self-checking testbench for projection_profile_segmenter.
// Drives projection profiles, predicts every reported object and end marker, and checks them.
// Depends on pps_pkg and the segmenter RTL only.
`timescale 1ns / 1ps

module projection_profile_segmenter_tb;
  import pps_pkg::*;

  localparam int unsigned PROFILE_MAX   = MAX_LENGTH_DEFAULT;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned VALUE_TOP     = 4096;

  // Index past the end of the register list
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {RUN_IDLE, RUN_INK, RUN_GAP} run_phase_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [VALUE_W-1:0]   proj_value_i;
  logic                 final_position_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [START_W-1:0]   seg_start_o;
  logic [LENGTH_W-1:0]  seg_length_o;
  logic                 seg_valid_o;
  logic                 frame_done_o;
  logic                 run_last_o;

  projection_profile_segmenter DUT (.*);

  // Shadow of the configuration registers
  logic [CFG_W-1:0]    ink_thr;
  logic [CFG_W-1:0]    gap_min;
  logic [CFG_W-1:0]    obj_min;

  // Shadow of the segmentation state
  run_phase_e          run_phase;
  logic [START_W-1:0]  obj_begin;
  logic [LENGTH_W-1:0] gap_begin;
  logic [LENGTH_W-1:0] position;

  result_t     item_results[$];
  result_t     expected_segments[$];

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned items_sent;
  int unsigned items_accepted;
  int unsigned results_checked;
  int unsigned profiles_sent;
  int unsigned mismatches;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop for a hung handshake
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver back-pressure, changed on the falling edge
  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < stall_pct);
  end

  // Close the open object; report it if long enough
  function automatic void close_segment(int unsigned end_excl);
    int unsigned len;
    result_t     r;
    len = end_excl - obj_begin;
    if (len >= obj_min) begin
      r            = '0;
      r.seg_start  = obj_begin;
      r.seg_length = len[LENGTH_W-1:0];
      r.seg_valid  = 1'b1;
      item_results = {item_results, r};
    end
    run_phase = RUN_IDLE;
  endfunction

  // Advance the profile state by one accepted position and queue what it reports
  function automatic void track_profile(logic [VALUE_W-1:0] value, logic last_pos);
    int unsigned need;
    int unsigned span;
    result_t     r;
    item_results.delete();
    need = (gap_min == 0) ? 1 : gap_min;
    if (value > ink_thr) begin
      if (run_phase == RUN_IDLE) obj_begin = position[START_W-1:0];
      run_phase = RUN_INK;
    end else if (run_phase != RUN_IDLE) begin
      if (run_phase == RUN_INK) begin
        gap_begin = position;
        run_phase = RUN_GAP;
      end
      span = position - gap_begin + 1;
      if (span >= need) close_segment(gap_begin);
    end

    if (last_pos) begin
      if (run_phase == RUN_INK) close_segment(int'(position) + 1);
      else if (run_phase == RUN_GAP) close_segment(gap_begin);
      r            = '0;
      r.frame_done = 1'b1;
      item_results = {item_results, r};
      run_phase = RUN_IDLE;
      position  = '0;
    end else if (position < PROFILE_MAX - 1) begin
      position++;
    end

    if (item_results.size() > 0) begin
      item_results[item_results.size() - 1].run_last = 1'b1;
    end
    foreach (item_results[i]) expected_segments = {expected_segments, item_results[i]};
  endfunction

  function automatic void compare_field(string name, logic [LENGTH_W-1:0] want,
                                        logic [LENGTH_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result();
    result_t head;
    if (expected_segments.size() == 0) begin
      $error("result with no expectation: start %0d length %0d valid %0b done %0b last %0b",
             seg_start_o, seg_length_o, seg_valid_o, frame_done_o, run_last_o);
      mismatches++;
    end else begin
      head = expected_segments.pop_front();
      compare_field("seg_start", head.seg_start, seg_start_o);
      compare_field("seg_length", head.seg_length, seg_length_o);
      compare_field("seg_valid", head.seg_valid, seg_valid_o);
      compare_field("frame_done", head.frame_done, frame_done_o);
      compare_field("run_last", head.run_last, run_last_o);
      results_checked++;
    end
  endfunction

  // Observe both channels on the rising edge: predict on input, check on output
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        track_profile(proj_value_i, final_position_i);
        items_accepted++;
      end
      if (out_valid_o && !out_stall_i) check_result();
    end
  end

  // Offer one position; hold it until the block takes the transaction
  task automatic send_item(input logic [VALUE_W-1:0] value, input logic last_pos);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    proj_value_i     = value;
    final_position_i = last_pos;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (last_pos) profiles_sent++;
  endtask

  // Drop valid and wait until every predicted result has come out
  task automatic hold_until_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_segments.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    case (idx)
      REG_INK_THRESHOLD:     ink_thr = data;
      REG_MIN_GAP_LENGTH:    gap_min = data;
      REG_MIN_OBJECT_LENGTH: obj_min = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic apply_config(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] gap,
                              input logic [CFG_W-1:0] obj);
    hold_until_drained();
    write_reg(REG_INK_THRESHOLD, thr);
    write_reg(REG_MIN_GAP_LENGTH, gap);
    write_reg(REG_MIN_OBJECT_LENGTH, obj);
  endtask

  // Values just above the threshold are favoured to hit the compare boundary
  function automatic logic [VALUE_W-1:0] ink_value();
    if (ink_thr >= VALUE_TOP) return VALUE_W'(VALUE_TOP);
    if ($urandom_range(3) == 0) return ink_thr + VALUE_W'(1);
    return VALUE_W'($urandom_range(VALUE_TOP, ink_thr + 1));
  endfunction

  function automatic logic [VALUE_W-1:0] gap_value();
    if ($urandom_range(3) == 0) return ink_thr;
    return VALUE_W'($urandom_range(ink_thr, 0));
  endfunction

  task automatic randomise_config();
    logic [CFG_W-1:0] thr;
    logic [CFG_W-1:0] gap;
    logic [CFG_W-1:0] obj;
    case ($urandom_range(19))
      0:       thr = '0;
      1:       thr = CFG_W'(VALUE_TOP);
      2:       thr = CFG_W'(VALUE_TOP - 1);
      default: thr = CFG_W'($urandom_range(VALUE_TOP, 0));
    endcase
    case ($urandom_range(9))
      0:       gap = '0;
      1:       gap = CFG_W'(VALUE_TOP);
      default: gap = CFG_W'($urandom_range(6, 1));
    endcase
    case ($urandom_range(19))
      0, 1:    obj = '0;
      2:       obj = CFG_W'(VALUE_TOP);
      default: obj = CFG_W'($urandom_range(8, 1));
    endcase
    apply_config(thr, gap, obj);
  endtask

  // Defaults, extreme values, absorbed and closing gaps, two results from one item
  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_item(13'd0, 1'b1);
    send_item(13'd5, 1'b0);
    send_item(13'd4096, 1'b0);
    send_item(13'd0, 1'b0);
    send_item(13'd1, 1'b1);
    apply_config(13'd4096, 13'd1, 13'd1);
    send_item(13'd4096, 1'b0);
    send_item(13'd0, 1'b1);
    apply_config(13'd100, 13'd3, 13'd3);
    send_item(13'd200, 1'b0);
    send_item(13'd101, 1'b0);
    send_item(13'd100, 1'b0);
    send_item(13'd50, 1'b0);
    send_item(13'd200, 1'b0);
    send_item(13'd0, 1'b0);
    send_item(13'd0, 1'b0);
    send_item(13'd0, 1'b0);
    send_item(13'd200, 1'b0);
    send_item(13'd1, 1'b1);
    // zero gap length behaves as one, zero object length reports everything
    apply_config(13'd100, 13'd0, 13'd0);
    send_item(13'd200, 1'b0);
    send_item(13'd0, 1'b0);
    send_item(13'd200, 1'b0);
    send_item(13'd200, 1'b1);
    hold_until_drained();
    // an index past the register list must leave the settings alone
    write_reg(REG_UNUSED, 13'h1FFF);
    send_item(13'd101, 1'b0);
    send_item(13'd0, 1'b1);
  endtask

  // Pause mid-profile, with an object open, until the output side is empty
  task automatic test_pause_until_drained();
    send_idle_pct = 31;
    stall_pct     = 31;
    apply_config(13'd50, 13'd2, 13'd1);
    send_item(13'd60, 1'b0);
    send_item(13'd60, 1'b0);
    send_item(13'd0, 1'b0);
    send_item(13'd0, 1'b0);
    send_item(13'd60, 1'b0);
    hold_until_drained();
    send_item(13'd0, 1'b0);
    send_item(13'd60, 1'b0);
    send_item(13'd0, 1'b0);
    send_item(13'd60, 1'b1);
  endtask

  // Profiles built from ink and gap runs sized around the current gap length
  task automatic test_random_profiles(input int unsigned idle_pct,
                                      input int unsigned stall_in_pct,
                                      input int unsigned item_target);
    int unsigned        start_items;
    int unsigned        plen;
    int unsigned        done_here;
    int unsigned        run_len;
    int unsigned        gap_top;
    logic               ink_turn;
    logic [VALUE_W-1:0] v;
    send_idle_pct = idle_pct;
    stall_pct     = stall_in_pct;
    start_items   = items_sent;
    while (items_sent - start_items < item_target) begin
      if ($urandom_range(3) == 0) randomise_config();
      plen      = ($urandom_range(9) == 0) ? $urandom_range(200, 41) : $urandom_range(40, 1);
      done_here = 0;
      ink_turn  = 1'($urandom_range(1));
      while (done_here < plen) begin
        gap_top = (gap_min > 8) ? 10 : gap_min + 2;
        run_len = ink_turn ? $urandom_range(6, 1) : $urandom_range(gap_top, 0);
        for (int unsigned k = 0; k < run_len && done_here < plen; k++) begin
          if ($urandom_range(9) == 0) v = VALUE_W'($urandom_range(VALUE_TOP, 0));
          else v = ink_turn ? ink_value() : gap_value();
          done_here++;
          send_item(v, done_here == plen);
          if ($urandom_range(299) == 0) hold_until_drained();
        end
        ink_turn = !ink_turn;
      end
    end
  endtask

  initial begin
    int unsigned wait_count;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    proj_value_i     = '0;
    final_position_i = 1'b0;
    out_stall_i      = 1'b0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    items_sent       = 0;
    items_accepted   = 0;
    results_checked  = 0;
    profiles_sent    = 0;
    mismatches       = 0;
    cycle_count      = 0;
    ink_thr          = 13'd0;
    gap_min          = 13'd1;
    obj_min          = 13'd1;
    run_phase        = RUN_IDLE;
    obj_begin        = '0;
    gap_begin        = '0;
    position         = '0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_pause_until_drained();
    test_random_profiles(0, 0, 475);
    test_random_profiles(67, 0, 475);
    test_random_profiles(0, 67, 475);
    test_random_profiles(31, 31, 475);

    // Drain what is left, bounded
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait_count = 0;
    while (expected_segments.size() != 0 && wait_count < DRAIN_LIMIT) begin
      @(posedge clk_i);
      wait_count++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_segments.size() != 0) begin
      $error("%0d expected results never arrived", expected_segments.size());
      mismatches += expected_segments.size();
    end

    $display("Covered %0d positions in %0d profiles, %0d results checked,", items_accepted,
             profiles_sent, results_checked);
    $display("across varied thresholds, gap and object limits and idling mixes.");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
